// ===== design/ils_pkg.sv =====
`timescale 1ns / 1ps

package ils_pkg;

    // Default sizes of the store.
    localparam int LST_DEPTH       = 256;
    localparam int LST_VALUE_WIDTH = 32;

    // Request codes.
    localparam logic [3:0] REQ_PUSH   = 4'd0;
    localparam logic [3:0] REQ_POP    = 4'd1;
    localparam logic [3:0] REQ_INSERT = 4'd2;
    localparam logic [3:0] REQ_REMOVE = 4'd3;
    localparam logic [3:0] REQ_SWAP   = 4'd4;
    localparam logic [3:0] REQ_GET    = 4'd5;
    localparam logic [3:0] REQ_SET    = 4'd6;
    localparam logic [3:0] REQ_CLEAR  = 4'd7;
    localparam logic [3:0] REQ_SEARCH = 4'd8;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD      = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // One finished result on its way from the sequencer to the output register.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value_out;
        logic [7:0]  found_at;
        logic [8:0]  length;
    } ils_result_t;

endpackage

// ===== design/ils_ram.sv =====
`timescale 1ns / 1ps

module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/ils_seq.sv =====
`timescale 1ns / 1ps

module ils_seq import ils_pkg::*; #(
    parameter int DEPTH       = LST_DEPTH,
    parameter int VALUE_WIDTH = LST_VALUE_WIDTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [3:0]               req_type,
    input  logic [8:0]               position,
    input  logic [31:0]              value_in,
    output logic                     res_valid,
    input  logic                     res_ready,
    output ils_result_t              res,
    output logic                     mem_we,
    output logic [$clog2(DEPTH)-1:0] mem_waddr,
    output logic [VALUE_WIDTH-1:0]   mem_wdata,
    output logic [$clog2(DEPTH)-1:0] mem_raddr,
    input  logic [VALUE_WIDTH-1:0]   mem_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDW  = 3'd1;
    localparam logic [2:0] S_SWP  = 3'd2;
    localparam logic [2:0] S_SHDN = 3'd3;
    localparam logic [2:0] S_SHUP = 3'd4;
    localparam logic [2:0] S_SRCH = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]             state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [3:0]             req_reg, req_next;
    logic [CW-1:0]          pos_reg, pos_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [VALUE_WIDTH-1:0] old_reg, old_next;
    logic [CW-1:0]          ptr_reg, ptr_next;
    logic                   pend_reg, pend_next;
    logic [AW-1:0]          waddr_reg, waddr_next;
    ils_result_t            res_reg, res_next;

    logic [CW-1:0]          cnt_m1;
    logic [CW-1:0]          ptr_m1;
    logic [31:0]            pos32;
    logic [31:0]            cnt32;
    logic                   fin;
    logic [1:0]             fin_status;
    logic [VALUE_WIDTH-1:0] fin_value;
    logic [AW-1:0]          fin_idx;

    assign cnt_m1    = count_reg - CW'(1);
    assign ptr_m1    = ptr_reg - CW'(1);
    assign pos32     = 32'(position);
    assign cnt32     = 32'(count_reg);
    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_FIN);
    assign res       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        req_next   = req_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        old_next   = old_reg;
        ptr_next   = ptr_reg;
        pend_next  = pend_reg;
        waddr_next = waddr_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = waddr_reg;
        mem_wdata  = mem_rdata;
        mem_raddr  = '0;
        fin        = 1'b0;
        fin_status = ST_OK;
        fin_value  = '0;
        fin_idx    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next = req_type;
                    pos_next = CW'(position);
                    val_next = VALUE_WIDTH'(value_in);
                    case (req_type)
                        REQ_PUSH:
                        begin
                            if (cnt32 >= 32'(DEPTH))
                            begin
                                fin        = 1'b1;
                                fin_status = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[AW-1:0];
                                mem_wdata  = VALUE_WIDTH'(value_in);
                                count_next = count_reg + CW'(1);
                                fin        = 1'b1;
                            end
                        end
                        REQ_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_BAD;
                            end
                            else
                            begin
                                mem_raddr  = cnt_m1[AW-1:0];
                                state_next = S_RDW;
                            end
                        end
                        REQ_INSERT:
                        begin
                            if (pos32 > cnt32)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_BAD;
                            end
                            else if (cnt32 >= 32'(DEPTH))
                            begin
                                fin        = 1'b1;
                                fin_status = ST_FULL;
                            end
                            else
                            begin
                                ptr_next   = count_reg;
                                pend_next  = 1'b0;
                                state_next = S_SHUP;
                            end
                        end
                        REQ_REMOVE, REQ_SWAP, REQ_GET, REQ_SET:
                        begin
                            if (pos32 >= cnt32)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_BAD;
                            end
                            else
                            begin
                                mem_raddr  = AW'(position);
                                state_next = S_RDW;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                            fin        = 1'b1;
                        end
                        REQ_SEARCH:
                        begin
                            ptr_next   = '0;
                            pend_next  = 1'b0;
                            state_next = S_SRCH;
                        end
                        default:
                        begin
                            fin        = 1'b1;
                            fin_status = ST_BAD;
                        end
                    endcase
                end
            end
            S_RDW:
            begin
                case (req_reg)
                    REQ_POP:
                    begin
                        count_next = cnt_m1;
                        fin        = 1'b1;
                        fin_value  = mem_rdata;
                    end
                    REQ_SET:
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = pos_reg[AW-1:0];
                        mem_wdata = val_reg;
                        fin       = 1'b1;
                        fin_value = mem_rdata;
                    end
                    REQ_SWAP:
                    begin
                        old_next   = mem_rdata;
                        mem_raddr  = cnt_m1[AW-1:0];
                        state_next = S_SWP;
                    end
                    REQ_REMOVE:
                    begin
                        old_next   = mem_rdata;
                        ptr_next   = pos_reg + CW'(1);
                        pend_next  = 1'b0;
                        state_next = S_SHDN;
                    end
                    default:
                    begin
                        fin       = 1'b1;
                        fin_value = mem_rdata;
                    end
                endcase
            end
            S_SWP:
            begin
                // The last entry fills the hole; harmless when both are the same.
                mem_we     = 1'b1;
                mem_waddr  = pos_reg[AW-1:0];
                mem_wdata  = mem_rdata;
                count_next = cnt_m1;
                fin        = 1'b1;
                fin_value  = old_reg;
            end
            S_SHDN:
            begin
                // Read entry ptr, write it one place lower in the next cycle.
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = waddr_reg;
                    mem_wdata = mem_rdata;
                end
                if (ptr_reg < count_reg)
                begin
                    mem_raddr  = ptr_reg[AW-1:0];
                    pend_next  = 1'b1;
                    waddr_next = ptr_m1[AW-1:0];
                    ptr_next   = ptr_reg + CW'(1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    count_next = cnt_m1;
                    fin        = 1'b1;
                    fin_value  = old_reg;
                end
            end
            S_SHUP:
            begin
                // Walk down from the top, moving each entry one place higher.
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = waddr_reg;
                    mem_wdata = mem_rdata;
                end
                if (ptr_reg > pos_reg)
                begin
                    mem_raddr  = ptr_m1[AW-1:0];
                    pend_next  = 1'b1;
                    waddr_next = ptr_reg[AW-1:0];
                    ptr_next   = ptr_m1;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = pos_reg[AW-1:0];
                    mem_wdata  = val_reg;
                    count_next = count_reg + CW'(1);
                    fin        = 1'b1;
                end
            end
            S_SRCH:
            begin
                if (pend_reg && (mem_rdata == val_reg))
                begin
                    fin     = 1'b1;
                    fin_idx = waddr_reg;
                end
                else if (ptr_reg < count_reg)
                begin
                    mem_raddr  = ptr_reg[AW-1:0];
                    pend_next  = 1'b1;
                    waddr_next = ptr_reg[AW-1:0];
                    ptr_next   = ptr_reg + CW'(1);
                end
                else
                begin
                    fin        = 1'b1;
                    fin_status = ST_NOTFOUND;
                end
            end
            S_FIN:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            res_next.status    = fin_status;
            res_next.value_out = 32'(fin_value);
            res_next.found_at  = 8'(fin_idx);
            res_next.length    = 9'(count_next);
            state_next         = S_FIN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        old_reg   <= old_next;
        ptr_reg   <= ptr_next;
        waddr_reg <= waddr_next;
        res_reg   <= res_next;
    end

endmodule

// ===== design/indexed_list_store.sv =====
`timescale 1ns / 1ps

// Bounded ordered list of value handles held in one synchronous memory.
// Requests arrive on the slave stream (s_*): the request kind in s_tuser, the
// position and value in s_tdata. Each request gives exactly one result word on
// the master stream (m_*): status in m_tuser, value, search index and length
// in m_tdata.
// Push, clear and rejected requests finish in their accept cycle; pop, get
// and set read one entry and then finish, swap-remove reads two. Remove,
// insert and search walk the single memory read port one entry per cycle.
// Each result passes through the sequencer's result register to the output
// register, and the next request is accepted once the sequencer has handed
// its result on.
// The sequencer takes one request at a time. A finished result sits in the
// output register, so the next request is already accepted and worked on
// while the receiver stalls; the sequencer only waits once its own result is
// ready and the output register is still full.
// Reset empties the list (length zero) at once; memory contents are not
// cleared and no entry is ever read before it was written.
module indexed_list_store import ils_pkg::*; #(
    parameter int DEPTH       = LST_DEPTH,
    parameter int VALUE_WIDTH = LST_VALUE_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // position[8:0], value_in[40:9], zero fill
    input  logic [3:0]  s_tuser,   // req_type[3:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // value_out[31:0], found_at[39:32], length[48:40]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int AW = $clog2(DEPTH);

    logic                   res_valid;
    logic                   res_ready;
    ils_result_t            res;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]          mem_raddr;
    logic [VALUE_WIDTH-1:0] mem_rdata;

    logic                   out_valid_reg, out_valid_next;
    ils_result_t            out_reg, out_next;

    // The entries of the list.
    ils_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Request sequencer: bounds checks, read-modify-write and the entry walks.
    ils_seq #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .req_type  (s_tuser),
        .position  (s_tdata[8:0]),
        .value_in  (s_tdata[40:9]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // The output register takes a new result when empty or being drained.
    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {7'b0, out_reg.length, out_reg.found_at, out_reg.value_out};

endmodule
